// ===== hw/rtl/dijkstra_shortest_paths_core_assert.svh =====
// assertion macros shared by the shortest path core files
`ifndef DIJKSTRA_SHORTEST_PATHS_CORE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dsp: assertion failed");
`define DSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsp: implication failed");
`else
`define DSP_ASSERT(lbl, clk, rst, prop)
`define DSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/dsp_pkg.sv =====
// shared types and constants for the shortest path core
`timescale 1ns / 1ps
package dsp_pkg;
   localparam int ACTION_W = 2;
   localparam int NODE_W   = 4;
   localparam int WEIGHT_W = 16;
   localparam int COST_W   = 20;
   localparam int CFG_W    = 5;

   // largest node space the result fields can describe
   localparam int NODE_LIMIT = 16;

   localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
   localparam logic [COST_W-1:0] COST_MAX  = 20'hFFFFF;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd3;

   // command queue depth, power of two
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_ADD,
      CMD_MODIFY,
      CMD_REMOVE,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_W-1:0]   source_node;
   } cmd_type;
endpackage

// ===== hw/rtl/dsp_if.sv =====
// request, response and register write channels of the shortest path core
`timescale 1ns / 1ps
interface dsp_req_if
   import dsp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [NODE_W-1:0]   from_node;
   logic [NODE_W-1:0]   to_node;
   logic [WEIGHT_W-1:0] edge_weight;
   logic [NODE_W-1:0]   source_node;

   modport source (output valid, action, from_node, to_node, edge_weight, source_node,
                   input ready);
   modport sink   (input valid, action, from_node, to_node, edge_weight, source_node,
                   output ready);
endinterface

interface dsp_rsp_if
   import dsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] node_index;
   logic [COST_W-1:0] path_cost;
   logic              reachable;
   logic [NODE_W-1:0] predecessor;
   logic              has_predecessor;
   logic              last;

   modport source (output valid, node_index, path_cost, reachable, predecessor,
                   has_predecessor, last, input ready);
   modport sink   (input valid, node_index, path_cost, reachable, predecessor,
                   has_predecessor, last, output ready);
endinterface

interface dsp_csr_if
   import dsp_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] active_nodes;

   modport source (output valid, active_nodes, input ready);
   modport sink   (input valid, active_nodes, output ready);
endinterface

// ===== hw/rtl/dijkstra_shortest_paths_core.sv =====
// Dense single-source shortest path core. Request beats add, modify or remove a
// directed weighted edge, or start a run from a source node; edges live in a cost
// RAM with present bits that reset clears. A run covers nodes 0 to n-1, with n
// taken from the active_nodes register, and returns n response beats in node
// order, the final one flagged last. Edge beats are applied by the back end while
// it is idle and produce no response. Each settled node sweeps its row of the cost
// RAM one word per cycle, and the pick of the next node rides along that sweep. A
// two-entry command queue keeps accepting beats while a run is in progress, until
// it is full. Write active_nodes only while the core is idle.
`timescale 1ns / 1ps
module dijkstra_shortest_paths_core
   import dsp_pkg::*;
#(
   parameter int NODE_COUNT  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   dsp_req_if.sink    req_bus,
   dsp_rsp_if.source  rsp_bus,
   dsp_csr_if.sink    csr_bus
);
   logic             cmd_valid;
   logic             cmd_ready;
   cmd_type          cmd;
   logic [CFG_W-1:0] active_nodes_ff, active_nodes_in;

   assign csr_bus.ready   = 1'b1;
   assign active_nodes_in = csr_bus.valid ? csr_bus.active_nodes : active_nodes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_nodes_ff <= CFG_RESET;
      end else begin
         active_nodes_ff <= active_nodes_in;
      end
   end

   dsp_front #(
      .NODE_COUNT(NODE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   dsp_back #(
      .NODE_COUNT  (NODE_COUNT),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .active_nodes (active_nodes_ff),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp          (rsp_bus)
   );
endmodule

// ===== hw/rtl/dsp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module dsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== hw/rtl/dsp_front.sv =====
// front end: takes request beats, classifies them and queues commands
`timescale 1ns / 1ps
`include "dijkstra_shortest_paths_core_assert.svh"
module dsp_front
   import dsp_pkg::*;
#(
   parameter int NODE_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   dsp_req_if.sink    req,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);
   localparam int QAW = $clog2(CMDQ_DEPTH);

   cmd_type        item;
   logic           in_range;
   logic           push;
   logic           pop;
   cmd_type        q_ff [CMDQ_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   assign in_range = (int'(req.from_node) < NODE_COUNT) && (int'(req.to_node) < NODE_COUNT);

   always_comb begin
      item.from_node   = req.from_node;
      item.to_node     = req.to_node;
      item.weight      = req.edge_weight;
      item.source_node = req.source_node;
      case (req.action)
         ACT_ADD:    item.kind = in_range ? CMD_ADD : CMD_NOP;
         ACT_MODIFY: item.kind = in_range ? CMD_MODIFY : CMD_NOP;
         ACT_REMOVE: item.kind = in_range ? CMD_REMOVE : CMD_NOP;
         ACT_RUN:    item.kind = CMD_RUN;
         default:    item.kind = CMD_NOP;
      endcase
   end

   assign req.ready = (count_ff != (QAW+1)'(CMDQ_DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   `DSP_ASSERT(a_queue_bound, clock, reset, count_ff <= (QAW+1)'(CMDQ_DEPTH))
endmodule

// ===== hw/rtl/dsp_back.sv =====
// back end: edge store, relaxation sequencer and result output register
`timescale 1ns / 1ps
`include "dijkstra_shortest_paths_core_assert.svh"
module dsp_back
   import dsp_pkg::*;
#(
   parameter int NODE_COUNT  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] active_nodes,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd,
   dsp_rsp_if.source        rsp
);
   localparam int NEFF  = (NODE_COUNT < NODE_LIMIT) ? NODE_COUNT : NODE_LIMIT;
   localparam int NB    = $clog2(NEFF);
   localparam int CNTW  = NB + 1;
   localparam int AW    = 2 * NB;
   localparam int SLOTS = 1 << AW;
   localparam int DW    = WEIGHT_BITS + NB;
   localparam int CW    = (DW > COST_W) ? DW : COST_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RELAX = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNTW-1:0]        n_ff, n_in;
   logic [CNTW-1:0]        j_ff, j_in;
   logic [NB-1:0]          u_ff, u_in;
   logic [DW-1:0]          du_ff, du_in;
   logic [SLOTS-1:0]       present_ff, present_in;
   logic [NEFF-1:0]        finite_ff, finite_in;
   logic [NEFF-1:0]        done_ff, done_in;
   logic [NEFF-1:0]        pvalid_ff, pvalid_in;
   logic [DW-1:0]          dist_ff [NEFF];
   logic [DW-1:0]          dist_in [NEFF];
   logic [NB-1:0]          prev_ff [NEFF];
   logic [NB-1:0]          prev_in [NEFF];

   logic                   p1_valid_ff, p1_valid_in;
   logic [NB-1:0]          p1_idx_ff, p1_idx_in;
   logic                   p1_pres_ff, p1_pres_in;
   logic                   p2_valid_ff, p2_valid_in;
   logic [NB-1:0]          p2_idx_ff, p2_idx_in;
   logic [DW-1:0]          p2_dist_ff, p2_dist_in;
   logic                   p2_cand_ff, p2_cand_in;
   logic                   found_ff, found_in;
   logic [DW-1:0]          best_ff, best_in;
   logic [NB-1:0]          pick_ff, pick_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]      rsp_node_ff, rsp_node_in;
   logic [COST_W-1:0]      rsp_cost_ff, rsp_cost_in;
   logic                   rsp_reach_ff, rsp_reach_in;
   logic [NODE_W-1:0]      rsp_pred_ff, rsp_pred_in;
   logic                   rsp_haspred_ff, rsp_haspred_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [WEIGHT_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [WEIGHT_BITS-1:0] rd_data;

   logic [CNTW-1:0]        n_cfg;
   logic                   src_ok;
   logic [NB-1:0]          src_idx;
   logic [31:0]            weight_ext;
   logic [DW-1:0]          p1_dist;
   logic                   p1_fin;
   logic                   p1_done;
   logic [DW:0]            cand;
   logic                   relax_hit;
   logic [NB-1:0]          out_idx;
   logic [CW-1:0]          out_cost_ext;

   dsp_ram #(
      .WIDTH(WEIGHT_BITS),
      .DEPTH(SLOTS)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // zero means one node, anything past the node space saturates
   always_comb begin
      if (active_nodes == '0) begin
         n_cfg = CNTW'(1);
      end else if (int'(active_nodes) > NEFF) begin
         n_cfg = CNTW'(NEFF);
      end else begin
         n_cfg = CNTW'(active_nodes);
      end
   end

   assign src_ok     = int'(cmd.source_node) < int'(n_cfg);
   assign src_idx    = cmd.source_node[NB-1:0];
   assign weight_ext = 32'(cmd.weight);
   assign wr_addr    = {cmd.from_node[NB-1:0], cmd.to_node[NB-1:0]};
   assign wr_data    = weight_ext[WEIGHT_BITS-1:0];
   assign rd_addr    = {u_ff, j_ff[NB-1:0]};

   // relax stage: cost word arrives from the registered RAM read in the cycle after the address
   assign p1_dist   = dist_ff[p1_idx_ff];
   assign p1_fin    = finite_ff[p1_idx_ff];
   assign p1_done   = done_ff[p1_idx_ff];
   assign cand      = {1'b0, du_ff} + (DW+1)'(rd_data);
   assign relax_hit = p1_valid_ff && p1_pres_ff && !p1_done &&
                      (!p1_fin || (cand < {1'b0, p1_dist}));

   assign out_idx      = j_ff[NB-1:0];
   assign out_cost_ext = CW'(dist_ff[out_idx]);

   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      j_in       = j_ff;
      u_in       = u_ff;
      du_in      = du_ff;
      present_in = present_ff;
      finite_in  = finite_ff;
      done_in    = done_ff;
      pvalid_in  = pvalid_ff;
      dist_in    = dist_ff;
      prev_in    = prev_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      pick_in    = pick_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;

      p1_valid_in = 1'b0;
      p1_idx_in   = j_ff[NB-1:0];
      p1_pres_in  = present_ff[rd_addr];

      if (relax_hit) begin
         dist_in[p1_idx_ff]   = cand[DW-1:0];
         finite_in[p1_idx_ff] = 1'b1;
         prev_in[p1_idx_ff]   = u_ff;
         pvalid_in[p1_idx_ff] = 1'b1;
      end
      p2_valid_in = p1_valid_ff;
      p2_idx_in   = p1_idx_ff;
      p2_dist_in  = relax_hit ? cand[DW-1:0] : p1_dist;
      p2_cand_in  = !p1_done && (p1_fin || relax_hit);

      // running minimum, first index wins on a tie
      if (p2_valid_ff && p2_cand_ff && (!found_ff || (p2_dist_ff < best_ff))) begin
         found_in = 1'b1;
         best_in  = p2_dist_ff;
         pick_in  = p2_idx_ff;
      end

      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_node_in    = rsp_node_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_reach_in   = rsp_reach_ff;
      rsp_pred_in    = rsp_pred_ff;
      rsp_haspred_in = rsp_haspred_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_ADD: begin
                     present_in[wr_addr] = 1'b1;
                     wr_en               = 1'b1;
                  end
                  CMD_MODIFY: begin
                     wr_en = present_ff[wr_addr];
                  end
                  CMD_REMOVE: begin
                     present_in[wr_addr] = 1'b0;
                  end
                  CMD_RUN: begin
                     n_in      = n_cfg;
                     j_in      = '0;
                     found_in  = 1'b0;
                     finite_in = '0;
                     done_in   = '0;
                     pvalid_in = '0;
                     if (src_ok) begin
                        finite_in[src_idx] = 1'b1;
                        done_in[src_idx]   = 1'b1;
                        dist_in[src_idx]   = '0;
                        u_in               = src_idx;
                        du_in              = '0;
                        state_in           = ST_RELAX;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RELAX: begin
            if (j_ff < n_ff) begin
               rd_en       = 1'b1;
               p1_valid_in = 1'b1;
               j_in        = j_ff + 1'b1;
            end else if (!p1_valid_ff && !p2_valid_ff) begin
               // sweep drained: settle the pick or finish the run
               j_in = '0;
               if (found_ff) begin
                  done_in[pick_ff] = 1'b1;
                  u_in             = pick_ff;
                  du_in            = best_ff;
                  found_in         = 1'b0;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (j_ff < n_ff) begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_in   = 1'b1;
                  rsp_node_in    = NODE_W'(out_idx);
                  rsp_reach_in   = finite_ff[out_idx];
                  rsp_haspred_in = pvalid_ff[out_idx];
                  rsp_pred_in    = pvalid_ff[out_idx] ? NODE_W'(prev_ff[out_idx]) : '0;
                  rsp_last_in    = (j_ff == n_ff - CNTW'(1));
                  if (!finite_ff[out_idx]) begin
                     rsp_cost_in = '0;
                  end else if (out_cost_ext > CW'(COST_MAX)) begin
                     rsp_cost_in = COST_MAX;
                  end else begin
                     rsp_cost_in = out_cost_ext[COST_W-1:0];
                  end
                  j_in = j_ff + 1'b1;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         finite_ff    <= '0;
         done_ff      <= '0;
         pvalid_ff    <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         finite_ff    <= finite_in;
         done_ff      <= done_in;
         pvalid_ff    <= pvalid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff           <= u_in;
      du_ff          <= du_in;
      dist_ff        <= dist_in;
      prev_ff        <= prev_in;
      p1_idx_ff      <= p1_idx_in;
      p1_pres_ff     <= p1_pres_in;
      p2_idx_ff      <= p2_idx_in;
      p2_dist_ff     <= p2_dist_in;
      p2_cand_ff     <= p2_cand_in;
      best_ff        <= best_in;
      pick_ff        <= pick_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_reach_ff   <= rsp_reach_in;
      rsp_pred_ff    <= rsp_pred_in;
      rsp_haspred_ff <= rsp_haspred_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.node_index      = rsp_node_ff;
   assign rsp.path_cost       = rsp_cost_ff;
   assign rsp.reachable       = rsp_reach_ff;
   assign rsp.predecessor     = rsp_pred_ff;
   assign rsp.has_predecessor = rsp_haspred_ff;
   assign rsp.last            = rsp_last_ff;

   `DSP_ASSERT_IMPLY(a_relax_node_done, clock, reset, state_ff == ST_RELAX, done_ff[u_ff])
   `DSP_ASSERT_IMPLY(a_cand_not_done, clock, reset, p2_valid_ff && p2_cand_ff, !done_ff[p2_idx_ff])
   `DSP_ASSERT_IMPLY(a_run_ends_last, clock, reset, state_ff == ST_OUT && j_ff == n_ff, rsp_last_ff)
endmodule
